/* rtl/evms_pkg.sv */
// Shared types, constants and a helper function for the even-value magnitude sorter.
package evms_pkg;

   localparam int unsigned DefaultListDepth = 64;
   localparam int unsigned SampleWidth      = 32;
   localparam int unsigned EvenBit          = 16;

   typedef logic [SampleWidth-1:0] sample_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_PIVOT,
      ST_SCAN,
      ST_WRITEBACK,
      ST_EMIT,
      ST_DRAIN
   } seq_state_type;

   // Two's complement magnitude; the most negative value maps to 2^31 as unsigned.
   function automatic sample_type magnitude_of(sample_type v);
      return v[SampleWidth-1] ? (sample_type'(0) - v) : v;
   endfunction

endpackage

/* rtl/even_value_magnitude_sorter_core.sv */
// Top level of the even-value magnitude sorter: list store, exchange sequencer and output.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------------------------
//   request   start / busy         req_sample_value (s32 Q16.16), req_final_element
//   response  rsp_strobe (1 cyc)   rsp_sorted_value (s32 Q16.16), rsp_end_of_list,
//                                  rsp_overflow
//
// Loading accepts one transaction per cycle while busy is low. The transaction marked final
// raises busy for the exchange pass and the output burst. For a list of n samples the pass
// has a start step, then a pivot step for each position i below n-1; an even pivot adds a
// scan over positions i+1 to n-1 and a write-back step. The burst emits the n entries and
// then drains. The single read port of the list memory is visited once per compare. Reset
// is synchronous and clears the sequencer, the element count and the overflow flag; memory
// contents are left as they are. The receiver cannot stall results.
module even_value_magnitude_sorter_core #(
   parameter int unsigned LIST_DEPTH = evms_pkg::DefaultListDepth
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [evms_pkg::SampleWidth-1:0] req_sample_value,
   input  logic                                   req_final_element,
   output logic                                   rsp_strobe,
   output logic signed [evms_pkg::SampleWidth-1:0] rsp_sorted_value,
   output logic                                   rsp_end_of_list,
   output logic                                   rsp_overflow
);
   import evms_pkg::*;

   // Address width for the list memory and count width that can also hold the depth itself.
   localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

   // List memory: one write port and one read port, read data registered.
   sample_type    store_mem [LIST_DEPTH];
   sample_type    rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   sample_type    wr_data;
   logic [AW-1:0] rd_addr;

   // Sequencer state.
   seq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   logic [AW-1:0] k_ff, k_in;
   sample_type    cur_ff, cur_in;
   sample_type    cur_mag_ff, cur_mag_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_last_ff, out_last_in;

   // Magnitude and parity of the word that the memory delivers this cycle.
   sample_type    rd_mag;
   logic          rd_even;
   logic [CW-1:0] last_idx;
   logic          more_pivots;

   assign rd_mag      = magnitude_of(rd_data_ff);
   assign rd_even     = ~rd_mag[EvenBit];
   assign last_idx    = count_ff - CW'(1);
   // True when the position after i still has a later element to compare against.
   assign more_pivots = (CW'(i_ff) + CW'(2)) < count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      cur_mag_ff  <= cur_mag_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      cur_mag_in   = cur_mag_ff;
      out_valid_in = 1'b0;
      out_last_in  = out_last_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = sample_type'($unsigned(req_sample_value));
      rd_addr      = '0;

      unique case (state_ff)
         ST_LOAD: begin
            // Store each transaction until the list is full; further samples only flag it.
            if (start) begin
               if (count_ff < CW'(LIST_DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_final_element) begin
                  state_in = ST_START;
               end
            end
         end

         ST_START: begin
            i_in = '0;
            k_in = '0;
            if (count_ff > CW'(1)) begin
               rd_addr  = '0;
               state_in = ST_PIVOT;
            end else begin
               state_in = ST_EMIT;
            end
         end

         ST_PIVOT: begin
            // The pivot stays in a register during its scan, so its memory entry is not read
            // again until it is written back.
            if (rd_even) begin
               cur_in     = rd_data_ff;
               cur_mag_in = rd_mag;
               rd_addr    = i_ff + AW'(1);
               j_in       = i_ff + AW'(1);
               state_in   = ST_SCAN;
            end else if (more_pivots) begin
               rd_addr = i_ff + AW'(1);
               i_in    = i_ff + AW'(1);
            end else begin
               k_in     = '0;
               state_in = ST_EMIT;
            end
         end

         ST_SCAN: begin
            // Element j arrives while element j+1 is being fetched; a swap writes the old
            // pivot to j and keeps the even sample of larger magnitude as the new pivot.
            if (rd_even && (cur_mag_ff < rd_mag)) begin
               wr_en      = 1'b1;
               wr_addr    = j_ff;
               wr_data    = cur_ff;
               cur_in     = rd_data_ff;
               cur_mag_in = rd_mag;
            end
            rd_addr = j_ff + AW'(1);
            j_in    = j_ff + AW'(1);
            if (CW'(j_ff) == last_idx) begin
               state_in = ST_WRITEBACK;
            end
         end

         ST_WRITEBACK: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = cur_ff;
            if (more_pivots) begin
               rd_addr  = i_ff + AW'(1);
               i_in     = i_ff + AW'(1);
               state_in = ST_PIVOT;
            end else begin
               k_in     = '0;
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            // Each fetched entry is presented in the next cycle straight from the read register.
            rd_addr      = k_ff;
            k_in         = k_ff + AW'(1);
            out_valid_in = 1'b1;
            out_last_in  = (CW'(k_ff) == last_idx);
            if (CW'(k_ff) == last_idx) begin
               state_in = ST_DRAIN;
            end
         end

         ST_DRAIN: begin
            // The final result is on the ports now; the next list starts from empty.
            count_in   = '0;
            dropped_in = 1'b0;
            state_in   = ST_LOAD;
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign busy             = (state_ff != ST_LOAD);
   assign rsp_strobe       = out_valid_ff;
   assign rsp_sorted_value = $signed(rd_data_ff);
   assign rsp_end_of_list  = out_last_ff;
   assign rsp_overflow     = dropped_ff;

endmodule
